### rtl/core/assert_macros.svh
// Assertion macros shared by the word order reverser RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/wor_pkg.sv
// Shared types and constants of the word order reverser.
// No dependencies; used by wor_ctrl, wor_datapath and word_order_reverser.
`default_nettype none

package wor_pkg;

    localparam int CHAR_W = 8;
    localparam logic [CHAR_W-1:0] SEP_RESET = 8'd32;

    // Which buffer address the datapath reads this cycle.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_TRIM,
        RD_SCAN,
        RD_EMIT
    } t_rd_sel;

    // What the output register is loaded with this cycle.
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_DATA,
        OUT_SEP,
        OUT_EMPTY
    } t_out_sel;

    typedef struct packed {
        logic     store;
        t_rd_sel  rd_sel;
        logic     trim;
        logic     seg_init;
        logic     scan_dec;
        logic     emit_init;
        t_out_sel out_sel;
        logic     seg_next;
        logic     clear;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_zero;
        logic scan_zero;
        logic scan_one;
        logic emit_end;
        logic rd_is_sep;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/core/wor_ctrl.sv
// Controller state machine of the word order reverser.
// Depends on wor_pkg for the command and status types.
`default_nettype none

module wor_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_line_end,
    input  wire wor_pkg::t_dp_status i_status,
    output logic                    o_in_ready,
    output wor_pkg::t_dp_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_SEG_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_INIT,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_SEG_END,
        S_EMPTY
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_LOAD);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.rd_sel    = wor_pkg::RD_NONE;
        o_cmd.out_sel   = wor_pkg::OUT_NONE;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_line_end) begin
                        n_state = S_TRIM_RD;
                    end
                end
            end
            S_TRIM_RD: begin
                if (i_status.fill_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd.rd_sel = wor_pkg::RD_TRIM;
                    n_state      = S_TRIM_CHK;
                end
            end
            S_TRIM_CHK: begin
                o_cmd.trim = 1'b1;
                n_state    = S_SEG_INIT;
            end
            S_SEG_INIT: begin
                if (i_status.fill_zero) begin
                    n_state = S_EMPTY;
                end else begin
                    o_cmd.seg_init = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_status.scan_zero) begin
                    n_state = S_EMIT_INIT;
                end else begin
                    o_cmd.rd_sel = wor_pkg::RD_SCAN;
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_status.rd_is_sep) begin
                    n_state = S_EMIT_INIT;
                end else begin
                    o_cmd.scan_dec = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_EMIT_INIT: begin
                o_cmd.emit_init = 1'b1;
                n_state         = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                if (i_status.emit_end) begin
                    n_state = S_SEG_END;
                end else begin
                    o_cmd.rd_sel = wor_pkg::RD_EMIT;
                    n_state      = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel = wor_pkg::OUT_DATA;
                    n_state       = S_EMIT_RD;
                end
            end
            S_SEG_END: begin
                if (i_status.scan_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_LOAD;
                end else if (i_status.out_free) begin
                    o_cmd.out_sel  = wor_pkg::OUT_SEP;
                    o_cmd.seg_next = 1'b1;
                    if (i_status.scan_one) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_LOAD;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel = wor_pkg::OUT_EMPTY;
                    o_cmd.clear   = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### rtl/core/wor_datapath.sv
// Datapath of the word order reverser: separator register, line buffer,
// pointers and output register. Depends on wor_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wor_datapath #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [wor_pkg::CHAR_W-1:0] i_cfg_wdata,
    input  wire logic [wor_pkg::CHAR_W-1:0] i_char_in,
    input  wire logic                       i_out_ready,
    input  wire wor_pkg::t_dp_cmd           i_cmd,
    output wor_pkg::t_dp_status             o_status,
    output logic                            o_out_valid,
    output logic [wor_pkg::CHAR_W-1:0]      o_char_out,
    output logic                            o_last_out,
    output logic                            o_empty_line,
    output logic                            o_overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam logic [CW-1:0] MAX_FILL = CW'(MAX_LEN);
    localparam logic [CW-1:0] ONE      = CW'(1);

    logic [wor_pkg::CHAR_W-1:0] r_sep;
    logic [wor_pkg::CHAR_W-1:0] r_mem [MAX_LEN];
    logic [wor_pkg::CHAR_W-1:0] r_rdata;

    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_scan, n_scan;
    logic [CW-1:0] r_we,   n_we;
    logic [CW-1:0] r_idx,  n_idx;
    logic          r_prev_sep, n_prev_sep;
    logic          r_dropped,  n_dropped;
    logic          r_o_valid,  n_o_valid;

    logic [wor_pkg::CHAR_W-1:0] r_o_char;
    logic                       r_o_last;
    logic                       r_o_empty;
    logic                       r_o_ovf;

    logic          is_sep;
    logic          do_store;
    logic          has_room;
    logic          mem_we;
    logic          rd_is_sep;
    logic [CW-1:0] fill_m1;
    logic [CW-1:0] scan_m1;
    logic [CW-1:0] we_m1;
    logic [AW-1:0] rd_addr;

    assign is_sep    = (i_char_in == r_sep);
    assign do_store  = i_cmd.store && (!is_sep || !r_prev_sep);
    assign has_room  = (r_fill != MAX_FILL);
    assign mem_we    = do_store && has_room;
    assign rd_is_sep = (r_rdata == r_sep);
    assign fill_m1   = r_fill - ONE;
    assign scan_m1   = r_scan - ONE;
    assign we_m1     = r_we - ONE;

    always_comb begin
        case (i_cmd.rd_sel)
            wor_pkg::RD_TRIM: rd_addr = fill_m1[AW-1:0];
            wor_pkg::RD_SCAN: rd_addr = scan_m1[AW-1:0];
            wor_pkg::RD_EMIT: rd_addr = r_idx[AW-1:0];
            default:          rd_addr = '0;
        endcase
    end

    always_comb begin
        n_fill     = r_fill;
        n_prev_sep = r_prev_sep;
        n_dropped  = r_dropped;
        n_scan     = r_scan;
        n_we       = r_we;
        n_idx      = r_idx;
        if (i_cmd.clear) begin
            n_fill     = '0;
            n_prev_sep = 1'b1;
            n_dropped  = 1'b0;
        end else begin
            if (mem_we) begin
                n_fill = r_fill + ONE;
            end else if (i_cmd.trim && rd_is_sep) begin
                n_fill = fill_m1;
            end
            if (i_cmd.store) begin
                n_prev_sep = is_sep;
            end
            if (do_store && !has_room) begin
                n_dropped = 1'b1;
            end
        end
        if (i_cmd.seg_init) begin
            n_scan = r_fill;
            n_we   = r_fill;
        end else if (i_cmd.scan_dec || i_cmd.seg_next) begin
            n_scan = scan_m1;
        end
        if (i_cmd.seg_next) begin
            n_we = scan_m1;
        end
        if (i_cmd.emit_init) begin
            n_idx = r_scan;
        end else if (i_cmd.out_sel == wor_pkg::OUT_DATA) begin
            n_idx = r_idx + ONE;
        end
        if (i_cmd.out_sel != wor_pkg::OUT_NONE) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep      <= wor_pkg::SEP_RESET;
            r_fill     <= '0;
            r_prev_sep <= 1'b1;
            r_dropped  <= 1'b0;
            r_scan     <= '0;
            r_we       <= '0;
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sep <= i_cfg_wdata;
            end
            r_fill     <= n_fill;
            r_prev_sep <= n_prev_sep;
            r_dropped  <= n_dropped;
            r_scan     <= n_scan;
            r_we       <= n_we;
            r_idx      <= n_idx;
            r_o_valid  <= n_o_valid;
        end
    end

    // Line buffer with a registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill[AW-1:0]] <= i_char_in;
        end
        if (i_cmd.rd_sel != wor_pkg::RD_NONE) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.out_sel)
            wor_pkg::OUT_DATA: begin
                r_o_char  <= r_rdata;
                r_o_last  <= (r_scan == '0) && (r_idx == we_m1);
                r_o_empty <= 1'b0;
                r_o_ovf   <= r_dropped;
            end
            wor_pkg::OUT_SEP: begin
                r_o_char  <= r_sep;
                r_o_last  <= (r_scan == ONE);
                r_o_empty <= 1'b0;
                r_o_ovf   <= r_dropped;
            end
            wor_pkg::OUT_EMPTY: begin
                r_o_char  <= '0;
                r_o_last  <= 1'b1;
                r_o_empty <= 1'b1;
                r_o_ovf   <= r_dropped;
            end
            default: begin
                r_o_char  <= r_o_char;
            end
        endcase
    end

    assign o_status.fill_zero = (r_fill == '0);
    assign o_status.scan_zero = (r_scan == '0);
    assign o_status.scan_one  = (r_scan == ONE);
    assign o_status.emit_end  = (r_idx == r_we);
    assign o_status.rd_is_sep = rd_is_sep;
    assign o_status.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid  = r_o_valid;
    assign o_char_out   = r_o_char;
    assign o_last_out   = r_o_last;
    assign o_empty_line = r_o_empty;
    assign o_overflow   = r_o_ovf;

    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= MAX_FILL, "fill count above capacity")
    `ASSERT_CLK(a_scan_le_end, i_clk, i_rst_n, r_scan <= r_we, "scan pointer past word end")
    `ASSERT_CLK(a_out_no_clobber, i_clk, i_rst_n,
        (i_cmd.out_sel != wor_pkg::OUT_NONE) |-> (!r_o_valid || i_out_ready),
        "output register loaded over an untaken result")

endmodule

`default_nettype wire

### rtl/core/word_order_reverser.sv
// Top level of the word order reverser: joins controller and datapath.
// Depends on wor_pkg, wor_ctrl and wor_datapath.
//
// Usage: bytes of a line arrive on the input channel (i_in_valid/o_in_ready),
// one byte per transfer, with i_line_end set on the final byte. While the
// line loads, one transfer is taken every cycle and no result is produced.
// After the final byte the block stops taking input, trims a trailing
// separator, and emits the words in reverse order on the output channel
// (o_out_valid/i_out_ready), one byte per transfer, with o_last_out on the
// final byte. A line without words gives a single transfer with
// o_empty_line and o_last_out set. o_overflow is set on every result of a
// line from which bytes were dropped because the buffer of MAX_LEN bytes
// was full. The separator is written through i_cfg_we/i_cfg_wdata.
// The line is loaded into the buffer and trimmed; each word is then found by a
// backward scan for its boundary and read out byte by byte through the
// output register. When the receiver stalls, the result waits in the output
// register and the sequencer holds. Synchronous reset restores the space
// separator and an empty line; the buffer contents need no clearing.
`default_nettype none

module word_order_reverser #(
    parameter int MAX_LEN = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_line_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_char_out,
    output logic            o_last_out,
    output logic            o_empty_line,
    output logic            o_overflow
);

    // Commands from the sequencer and status returned by the datapath.
    wor_pkg::t_dp_cmd    cmd;
    wor_pkg::t_dp_status status;

    wor_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_line_end (i_line_end),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // The datapath holds the buffer, the scan pointers and the output register;
    // beside separator writes and the output handshake it acts only on the command.
    wor_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_char_in    (i_char_in),
        .i_out_ready  (i_out_ready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_char_out   (o_char_out),
        .o_last_out   (o_last_out),
        .o_empty_line (o_empty_line),
        .o_overflow   (o_overflow)
    );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for word_order_reverser: directed lines, capacity
// overflow and random lines checked against a behavioural predictor.
// Depends on wor_pkg and word_order_reverser.
`default_nettype none

module tb;
    localparam int CHAR_W = wor_pkg::CHAR_W;
    localparam logic [CHAR_W-1:0] SEP_RESET = wor_pkg::SEP_RESET;

    localparam int MAX_LEN        = 64;
    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 10;
    localparam int ITEM_TARGET    = 210;
    // Settling time after the last expected result before a register write.
    localparam int DRAIN_SETTLE   = 8;
    // Idle wait at the end, sized from the buffer capacity.
    localparam int TAIL_CYCLES    = 4 * MAX_LEN + 8;
    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;
    // In directed text this character stands for the current separator.
    localparam logic [CHAR_W-1:0] SEP_MARK = 8'h5F;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    // One byte of a reordered line, as the block should present it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
        logic              is_empty;
        logic              ovf;
    } t_reorder_byte;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [CHAR_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic [CHAR_W-1:0] i_char_in   = '0;
    logic              i_line_end  = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [CHAR_W-1:0] o_char_out;
    logic              o_last_out;
    logic              o_empty_line;
    logic              o_overflow;

    // Predictor state: the compacted line, its fill level and the
    // separator-run tracking, mirroring what the block holds.
    logic [CHAR_W-1:0] line_buf [MAX_LEN];
    int                fill_level   = 0;
    logic              prev_sep     = 1'b1;
    logic              line_dropped = 1'b0;
    logic [CHAR_W-1:0] sep_reg      = SEP_RESET;

    // Bytes the block still owes us, oldest first.
    t_reorder_byte     pending_bytes [$];

    int                fail_count  = 0;
    int                items_sent  = 0;
    int                burst_left  = 0;
    int                idle_cycles = 0;

    t_rx_mode          rx_mode      = RX_OPEN;
    int                rx_mode_left = 0;
    int                rx_phase     = 0;

    word_order_reverser #(
        .MAX_LEN(MAX_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_in   (i_char_in),
        .i_line_end  (i_line_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_out  (o_char_out),
        .o_last_out  (o_last_out),
        .o_empty_line(o_empty_line),
        .o_overflow  (o_overflow)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Store one byte into the line buffer, or flag the line once it is full.
    function automatic void store_char(input logic [CHAR_W-1:0] ch);
        if (fill_level < MAX_LEN) begin
            line_buf[fill_level] = ch;
            fill_level++;
        end else begin
            line_dropped = 1'b1;
        end
    endfunction

    // Queue one byte that the block owes, tagged with the line's overflow.
    function automatic void owe_byte(input logic [CHAR_W-1:0] ch, input logic is_last,
                                     input logic is_empty);
        t_reorder_byte b;
        b.ch       = ch;
        b.is_last  = is_last;
        b.is_empty = is_empty;
        b.ovf      = line_dropped;
        pending_bytes.insert(pending_bytes.size(), b);
    endfunction

    // Take one accepted input byte into the predictor. On the final byte of a
    // line the words are queued in reverse order, joined by one separator,
    // and the line state starts afresh.
    function automatic void absorb_byte(input logic [CHAR_W-1:0] ch, input logic le);
        int word_end;
        int scan;
        if (ch == sep_reg) begin
            // Only the first separator of a run is kept, and none at the start.
            if (!prev_sep) store_char(ch);
            prev_sep = 1'b1;
        end else begin
            store_char(ch);
            prev_sep = 1'b0;
        end
        if (!le) return;

        // A trailing separator is dropped before emitting.
        if (fill_level > 0 && line_buf[fill_level-1] == sep_reg) fill_level--;

        if (fill_level == 0) begin
            // A line without words yields a single result flagged empty.
            owe_byte('0, 1'b1, 1'b1);
        end else begin
            word_end = fill_level;
            while (word_end > 0) begin
                scan = word_end;
                while (scan > 0 && line_buf[scan-1] != sep_reg) scan--;
                for (int i = scan; i < word_end; i++) begin
                    owe_byte(line_buf[i], 1'b0, 1'b0);
                end
                if (scan > 0) begin
                    owe_byte(sep_reg, 1'b0, 1'b0);
                    word_end = scan - 1;
                end else begin
                    word_end = 0;
                end
            end
            pending_bytes[pending_bytes.size()-1].is_last = 1'b1;
        end

        fill_level   = 0;
        prev_sep     = 1'b1;
        line_dropped = 1'b0;
    endfunction

    // Compare one result transfer with the oldest expected byte. The character
    // carries no meaning on an empty-line result, so it is not compared there.
    task automatic check_result();
        t_reorder_byte want;
        if (pending_bytes.size() == 0) begin
            $error("unexpected result: char_out %0h last_out %0b empty_line %0b",
                   o_char_out, o_last_out, o_empty_line);
            fail_count++;
        end else begin
            want = pending_bytes.pop_front();
            if (!want.is_empty && o_char_out !== want.ch) begin
                $error("char_out: expected %0h, got %0h", want.ch, o_char_out);
                fail_count++;
            end
            if (o_last_out !== want.is_last) begin
                $error("last_out: expected %0b, got %0b", want.is_last, o_last_out);
                fail_count++;
            end
            if (o_empty_line !== want.is_empty) begin
                $error("empty_line: expected %0b, got %0b", want.is_empty, o_empty_line);
                fail_count++;
            end
            if (o_overflow !== want.ovf) begin
                $error("overflow: expected %0b, got %0b", want.ovf, o_overflow);
                fail_count++;
            end
        end
    endtask

    // Result side. Signals are read straight after the edge, before any
    // nonblocking update of that step lands, so they hold their pre-edge
    // values. The ready line follows a pattern that changes every so often:
    // fully open, coin-toss, or sparse, open only when a wrapping phase is zero.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) check_result();
            if (rx_mode_left == 0) begin
                rx_mode_left = $urandom_range(16, 96);
                case ($urandom_range(0, 2))
                    0:       rx_mode = RX_OPEN;
                    1:       rx_mode = RX_RANDOM;
                    default: rx_mode = RX_SPARSE;
                endcase
            end
            rx_mode_left--;
            rx_phase = (rx_phase + 1) % 4;
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                default:   i_out_ready <= (rx_phase == 0);
            endcase
        end
    end

    // Watchdog: a run that makes no transfer on either side for too long
    // has hung.
    always @(posedge i_clk) begin
        if (i_rst_n && !((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[word_order_reverser] ERROR");
            $finish;
        end
    end

    // Offer one byte and wait for its transfer. The sender works in bursts
    // of random length; between bursts valid drops for a random gap, and a
    // quarter of the bursts follow on with no gap at all.
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic le);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_char_in  <= ch;
        i_line_end <= le;
        do @(posedge i_clk); while (!o_in_ready);
        absorb_byte(ch, le);
        items_sent++;
    endtask

    // Send a whole line written as text; the underscore stands for whatever
    // separator is currently set, and the last character ends the line.
    task automatic send_text(input string s);
        logic [CHAR_W-1:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == SEP_MARK) c = sep_reg;
            send_byte(c, i == s.len() - 1);
        end
    endtask

    // Let the block finish all owed results and settle, input held idle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // Change the separator; only ever called with the block idle.
    task automatic write_separator(input logic [CHAR_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sep_reg = value;
    endtask

    // Collapsing, trimming, a lone word, empty lines and the byte extremes,
    // all with the default space separator.
    task automatic test_basic_lines();
        send_text("_ab__cd_");
        send_text("x");
        send_text("_");
        send_text("___");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // The separator register at both extremes and at an ordinary value,
    // then back to the default.
    task automatic test_separator_values();
        write_separator(8'h00);
        send_text("a_b");
        write_separator(8'hFF);
        send_text("a_b");
        write_separator(8'h2C);
        send_text("a_b");
        write_separator(SEP_RESET);
    endtask

    // A line that fills the buffer exactly, then one that runs past it so
    // that both words and a separator find the buffer full.
    task automatic test_capacity();
        for (int i = 0; i < MAX_LEN; i++)
            send_byte(CHAR_W'(8'h41 + (i % 26)), i == MAX_LEN - 1);
        for (int i = 0; i < 40; i++)
            send_byte(CHAR_W'(8'h61 + (i % 26)), 1'b0);
        send_byte(sep_reg, 1'b0);
        for (int i = 0; i < 30; i++)
            send_byte(CHAR_W'(8'h30 + (i % 10)), 1'b0);
        send_byte(sep_reg, 1'b0);
        send_byte(8'h7A, 1'b1);
    endtask

    // Random lines, mostly short, some medium and a few around the capacity.
    // Bytes are weighted towards the separator and letters so that words
    // and separator runs form, with fully random bytes mixed in. Every so
    // often the separator is changed between lines.
    task automatic test_random_lines();
        int len;
        int since_cfg;
        int pick;
        logic [CHAR_W-1:0] c;
        since_cfg = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)      len = $urandom_range(1, 10);
            else if (pick < 96) len = $urandom_range(11, 30);
            else                len = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)      c = sep_reg;
                else if (pick < 75) c = CHAR_W'(8'h61 + $urandom_range(0, 25));
                else                c = CHAR_W'($urandom_range(0, 255));
                send_byte(c, i == len - 1);
            end
            since_cfg += len;
            if (since_cfg > 50) begin
                since_cfg = 0;
                if ($urandom_range(0, 1) == 0)
                    write_separator(SEP_RESET);
                else
                    write_separator(CHAR_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_lines();
        test_separator_values();
        test_capacity();
        test_random_lines();

        // Drain, then give any stray result time to show itself.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_bytes.size() == 0) begin
            $display("[word_order_reverser] OK");
        end else begin
            $display("[word_order_reverser] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
